### design/brf_pkg.sv
// Shared types and constants for the bit run finder.
`timescale 1ns / 1ps

package brf_pkg;

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	localparam int OFS_W = 6;

	typedef struct packed {
		logic             hit;
		logic [OFS_W-1:0] ofs;
	} win_res_t;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_PRIME = 4'b0010,
		S_SCAN  = 4'b0100,
		S_DONE  = 4'b1000
	} brf_state_t;

endpackage

### design/brf_window.sv
// Run detector over a two-word window that reports the lowest fitting start in the low word.
`timescale 1ns / 1ps

module brf_window import brf_pkg::*; #(
	parameter int WORD_BITS = 32,
	parameter int LW        = 6
) (
	input  logic [2*WORD_BITS-1:0] window,
	input  logic [LW-1:0]          len,
	output win_res_t               res
);

	logic [WORD_BITS-1:0] len_mask;
	logic [WORD_BITS-1:0] start_ok;

	always_comb begin
		for (int j = 0; j < WORD_BITS; j++) begin
			len_mask[j] = (j < int'(len));
		end
		for (int i = 0; i < WORD_BITS; i++) begin
			start_ok[i] = &(window[i +: WORD_BITS] | ~len_mask);
		end
	end

	always_comb begin
		res = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (start_ok[i]) begin
				res.hit = 1'b1;
				res.ofs = OFS_W'(i);
			end
		end
	end

endmodule

### design/bit_run_finder.sv
// Top level of the bit run finder: bitmap store, search sequencer and result register.
//
// The block keeps a bitmap of MAX_WORDS words, each WORD_BITS wide. A search word returns
// the lowest bit index at which run_length equal bits of the wanted polarity lie wholly
// inside the first word_count words; run_length 0 counts as 1, run_length is capped at
// WORD_BITS and word_count at MAX_WORDS. A search with word_count 0 skips the prime and
// scan states. The bitmap has a single registered read port, and one window detector
// checks the starts inside one word per cycle, so the scan moves one word per cycle and
// stops at the first hit. A stalled output holds the sequencer in its last state until
// the result register is free. The next word is taken as soon as the sequencer is back
// in its idle state, even while the last result still waits at the output.
`timescale 1ns / 1ps

module bit_run_finder import brf_pkg::*; #(
	parameter int WORD_BITS = 32,
	parameter int MAX_WORDS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 cmd,
	input  logic [5:0]           word_index,
	input  logic [WORD_BITS-1:0] word_data,
	input  logic [5:0]           run_length,
	input  logic                 match_zeros,
	input  logic [6:0]           word_count,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 found,
	output logic [10:0]          bit_index
);

	localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int CW = $clog2(MAX_WORDS + 1);
	localparam int LW = $clog2(WORD_BITS + 1);
	localparam int TW = $clog2(MAX_WORDS * WORD_BITS + 1);
	localparam int PW = (TW > 11) ? TW : 11;

	brf_state_t state_q;

	logic [WORD_BITS-1:0] bitmap_q [MAX_WORDS];
	logic [WORD_BITS-1:0] rd_data_q;
	logic [WORD_BITS-1:0] prev_q;
	logic [LW-1:0]        len_q;
	logic                 zeros_q;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        w_q;
	logic [PW-1:0]        base_q;
	logic                 pend_found_q;
	logic [10:0]          pend_idx_q;
	logic                 out_valid_q;
	logic                 found_q;
	logic [10:0]          bit_index_q;

	logic                 in_acc;
	logic                 wr_ok;
	logic [AW-1:0]        wr_addr;
	logic [AW-1:0]        rd_addr;
	logic [LW-1:0]        len_sat;
	logic [CW-1:0]        cnt_sat;
	logic [WORD_BITS-1:0] rd_match;
	logic [WORD_BITS-1:0] cur_match;
	win_res_t             win_res;
	logic [PW-1:0]        start_pos;
	logic                 out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign wr_ok     = (int'(word_index) < MAX_WORDS);
	assign wr_addr   = AW'(word_index);
	assign rd_match  = zeros_q ? ~rd_data_q : rd_data_q;
	assign cur_match = (w_q < cnt_q) ? rd_match : '0;
	assign start_pos = base_q + PW'(win_res.ofs);
	assign out_free  = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign bit_index = bit_index_q;

	always_comb begin
		case (state_q)
			S_PRIME: rd_addr = AW'(1);
			S_SCAN:  rd_addr = AW'(w_q) + AW'(1);
			default: rd_addr = '0;
		endcase
	end

	always_comb begin
		if (run_length == 6'd0) begin
			len_sat = LW'(1);
		end else if (int'(run_length) > WORD_BITS) begin
			len_sat = LW'(WORD_BITS);
		end else begin
			len_sat = LW'(run_length);
		end
		if (int'(word_count) > MAX_WORDS) begin
			cnt_sat = CW'(MAX_WORDS);
		end else begin
			cnt_sat = CW'(word_count);
		end
	end

	brf_window #(
		.WORD_BITS (WORD_BITS),
		.LW        (LW)
	) u_window (
		.window (({cur_match, prev_q})),
		.len    (len_q),
		.res    (win_res)
	);

	always_ff @(posedge clk) begin
		if (in_acc && cmd == CMD_LOAD && wr_ok) begin
			bitmap_q[wr_addr] <= word_data;
		end
		rd_data_q <= bitmap_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc && cmd == CMD_SEARCH) begin
					len_q        <= len_sat;
					zeros_q      <= match_zeros;
					cnt_q        <= cnt_sat;
					pend_found_q <= 1'b0;
					pend_idx_q   <= '0;
				end
			end
			S_PRIME: begin
				prev_q <= rd_match;
				w_q    <= CW'(1);
				base_q <= '0;
			end
			S_SCAN: begin
				if (win_res.hit) begin
					pend_found_q <= 1'b1;
					pend_idx_q   <= start_pos[10:0];
				end else if (w_q != cnt_q) begin
					prev_q <= cur_match;
					w_q    <= w_q + CW'(1);
					base_q <= base_q + PW'(WORD_BITS);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc && cmd == CMD_SEARCH) begin
						state_q <= (cnt_sat == '0) ? S_DONE : S_PRIME;
					end
				end
				S_PRIME: state_q <= S_SCAN;
				S_SCAN: begin
					if (win_res.hit || w_q == cnt_q) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			found_q     <= pend_found_q;
			bit_index_q <= pend_idx_q;
		end
	end

endmodule

### verif/bit_run_finder_tb.sv
// Self-checking testbench for the bit run finder: bitmap loads, run searches and result checks.
`timescale 1ns / 1ps

module bit_run_finder_tb import brf_pkg::*;;

	localparam int WORD_BITS    = 32;
	localparam int MAX_WORDS    = 64;
	localparam int RESET_CYCLES = 12;
	localparam int MAX_IDLE     = 16;
	localparam int RANDOM_ITEMS = 1400;
	localparam int DRAIN_CYCLES = 100;

	typedef struct packed {
		logic        found;
		logic [10:0] bit_index;
	} run_result_t;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 in_valid    = 1'b0;
	logic                 in_stall;
	logic                 cmd         = CMD_LOAD;
	logic [5:0]           word_index  = '0;
	logic [WORD_BITS-1:0] word_data   = '0;
	logic [5:0]           run_length  = 6'd1;
	logic                 match_zeros = 1'b0;
	logic [6:0]           word_count  = '0;
	logic                 out_valid;
	logic                 out_stall   = 1'b0;
	logic                 found;
	logic [10:0]          bit_index;

	logic [WORD_BITS-1:0] shadow_words [MAX_WORDS];
	bit                   word_loaded  [MAX_WORDS];
	run_result_t          pending_runs [$];

	int  errors        = 0;
	int  loads_sent    = 0;
	int  searches_sent = 0;
	int  runs_found    = 0;
	int  runs_missed   = 0;
	bit  steady        = 1'b0;

	always #1 clk = ~clk;

	bit_run_finder #(
		.WORD_BITS(WORD_BITS),
		.MAX_WORDS(MAX_WORDS)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.word_index (word_index),
		.word_data  (word_data),
		.run_length (run_length),
		.match_zeros(match_zeros),
		.word_count (word_count),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.found      (found),
		.bit_index  (bit_index)
	);

	function automatic run_result_t first_fit_run(logic [5:0] len_f, logic zeros,
			logic [6:0] cnt_f);
		run_result_t res;
		int          len;
		int          cnt;
		int          streak;
		int          pos;
		logic        want;
		res    = '0;
		len    = int'(len_f);
		cnt    = int'(cnt_f);
		want   = ~zeros;
		streak = 0;
		if (len == 0) begin
			len = 1;
		end
		if (len > WORD_BITS) begin
			len = WORD_BITS;
		end
		if (cnt > MAX_WORDS) begin
			cnt = MAX_WORDS;
		end
		for (pos = 0; pos < cnt * WORD_BITS; pos++) begin
			if (shadow_words[pos / WORD_BITS][pos % WORD_BITS] == want) begin
				streak++;
			end else begin
				streak = 0;
			end
			if (streak == len) begin
				res.found     = 1'b1;
				res.bit_index = 11'(pos + 1 - len);
				return res;
			end
		end
		return res;
	endfunction

	function automatic int loaded_prefix();
		int n;
		n = 0;
		while (n < MAX_WORDS && word_loaded[n]) begin
			n++;
		end
		return n;
	endfunction

	function automatic logic [WORD_BITS-1:0] random_pattern();
		logic [63:0] band;
		int          lo;
		int          w;
		lo   = int'($urandom_range(0, WORD_BITS - 1));
		w    = int'($urandom_range(1, WORD_BITS));
		band = ((64'd1 << w) - 64'd1) << lo;
		case ($urandom_range(0, 7))
			0: return '1;
			1: return '0;
			2: return $urandom;
			3: return ~(32'd1 << lo);
			4: return 32'd1 << lo;
			5: return band[WORD_BITS-1:0];
			6: return ~band[WORD_BITS-1:0];
			default: return $urandom & $urandom;
		endcase
	endfunction

	task automatic issue_word(logic op, logic [5:0] idx, logic [WORD_BITS-1:0] data,
			logic [5:0] len, logic zeros, logic [6:0] cnt);
		int gap;
		gap = steady ? 0 : int'($urandom_range(0, MAX_IDLE));
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		cmd         <= op;
		word_index  <= idx;
		word_data   <= data;
		run_length  <= len;
		match_zeros <= zeros;
		word_count  <= cnt;
		do @(posedge clk); while (in_stall);
		if (op == CMD_LOAD) begin
			shadow_words[idx] = data;
			word_loaded[idx]  = 1'b1;
			loads_sent++;
		end else begin
			pending_runs.push_back(first_fit_run(len, zeros, cnt));
			searches_sent++;
		end
	endtask

	task automatic load_word(int idx, logic [WORD_BITS-1:0] data);
		issue_word(CMD_LOAD, 6'(idx), data, 6'($urandom_range(0, 63)),
			1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)));
	endtask

	task automatic search_run(int len, logic zeros, int cnt);
		issue_word(CMD_SEARCH, 6'($urandom_range(0, 63)), $urandom, 6'(len), zeros, 7'(cnt));
	endtask

	task automatic random_search();
		int len;
		int cnt;
		int pick;
		int ready;
		pick  = int'($urandom_range(0, 99));
		ready = loaded_prefix();
		if (pick < 5) begin
			len = 0;
		end else if (pick < 12) begin
			len = int'($urandom_range(33, 63));
		end else if (pick < 20) begin
			len = WORD_BITS;
		end else if (pick < 60) begin
			len = int'($urandom_range(1, 8));
		end else begin
			len = int'($urandom_range(9, WORD_BITS - 1));
		end
		// A search never reaches a word that has not been loaded.
		if (ready < MAX_WORDS) begin
			cnt = int'($urandom_range(0, ready));
		end else begin
			pick = int'($urandom_range(0, 99));
			if (pick < 10) begin
				cnt = int'($urandom_range(65, 127));
			end else if (pick < 15) begin
				cnt = 0;
			end else if (pick < 25) begin
				cnt = MAX_WORDS;
			end else begin
				cnt = int'($urandom_range(1, MAX_WORDS - 1));
			end
		end
		search_run(len, 1'($urandom_range(0, 1)), cnt);
	endtask

	task automatic test_directed_edges();
		load_word(0, 32'hAAAA_AAAA);
		load_word(1, 32'h0000_0000);
		load_word(2, 32'hFFFF_0000);
		load_word(3, 32'h0000_FFFF);
		load_word(4, 32'hFFFF_FFFF);
		search_run(1, 1'b0, 0);
		search_run(1, 1'b1, 0);
		search_run(0, 1'b0, 1);
		search_run(1, 1'b1, 1);
		search_run(2, 1'b0, 1);
		search_run(16, 1'b0, 3);
		search_run(17, 1'b0, 3);
		search_run(32, 1'b0, 4);
		search_run(33, 1'b0, 4);
		search_run(63, 1'b0, 5);
		search_run(32, 1'b1, 2);
		search_run(33, 1'b1, 2);
		search_run(32, 1'b1, 1);
		search_run(2, 1'b1, 5);
		load_word(63, 32'h1234_5678);
	endtask

	task automatic test_full_map();
		int i;
		for (i = 0; i < MAX_WORDS - 1; i++) begin
			load_word(i, 32'h5555_5555);
		end
		load_word(MAX_WORDS - 1, 32'hFFFF_FFFF);
		search_run(2, 1'b0, 64);
		search_run(32, 1'b0, 127);
		search_run(1, 1'b0, 65);
		search_run(1, 1'b1, 127);
		search_run(2, 1'b1, 64);
		search_run(63, 1'b1, 127);
		search_run(32, 1'b0, 63);
		for (i = 0; i < MAX_WORDS; i++) begin
			load_word(i, random_pattern());
		end
		search_run(WORD_BITS, 1'b0, 64);
		search_run(WORD_BITS, 1'b1, 64);
	endtask

	task automatic test_random_traffic();
		int   goal;
		int   n;
		int   base;
		logic fill;
		goal = loads_sent + searches_sent + RANDOM_ITEMS;
		while (loads_sent + searches_sent < goal) begin
			steady = ($urandom_range(0, 5) == 0);
			n      = int'($urandom_range(0, 4));
			repeat (n) load_word(int'($urandom_range(0, MAX_WORDS - 1)), random_pattern());
			if ($urandom_range(0, 7) == 0) begin
				// A stretch of uniform words gives long runs across word boundaries.
				base = int'($urandom_range(0, MAX_WORDS - 4));
				fill = 1'($urandom_range(0, 1));
				n    = int'($urandom_range(2, 4));
				for (int i = 0; i < n; i++) begin
					load_word(base + i, {WORD_BITS{fill}});
				end
			end
			n = int'($urandom_range(1, 4));
			repeat (n) random_search();
		end
		steady = 1'b0;
	endtask

	initial begin : result_monitor
		run_result_t want;
		int          hold;
		wait (arst_n === 1'b1);
		forever begin
			hold = steady ? 0 : int'($urandom_range(0, MAX_IDLE));
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
			if (pending_runs.size() == 0) begin
				$error("result with no search pending: found=%0d bit_index=%0d",
					found, bit_index);
				errors++;
			end else begin
				want = pending_runs.pop_front();
				if (found !== want.found) begin
					$error("found: expected %0d, actual %0d", want.found, found);
					errors++;
				end
				if (bit_index !== want.bit_index) begin
					$error("bit_index: expected %0d, actual %0d", want.bit_index, bit_index);
					errors++;
				end
				if (want.found) begin
					runs_found++;
				end else begin
					runs_missed++;
				end
			end
		end
	end

	initial begin : run_limit
		#10_000_000;
		$display("timeout with %0d results outstanding", pending_runs.size());
		$display("** bit_run_finder: FAILED **");
		$finish;
	end

	initial begin : stimulus
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_edges();
		test_full_map();
		test_random_traffic();
		in_valid <= 1'b0;
		while (pending_runs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d bitmap loads and %0d run searches under random idling.",
			loads_sent, searches_sent);
		$display("Searches with a run: %0d, without a run: %0d, errors: %0d.",
			runs_found, runs_missed, errors);
		if (errors == 0) begin
			$display("** bit_run_finder: PASSED **");
		end else begin
			$display("** bit_run_finder: FAILED **");
		end
		$finish;
	end

endmodule

### bit_run_finder.f
design/brf_pkg.sv
design/brf_window.sv
design/bit_run_finder.sv
verif/bit_run_finder_tb.sv
